// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL, included by pf_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/pf_pkg.sv =====
package pf_pkg;

    // Input item kinds
    localparam logic [2:0] KIND_FMT   = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_STR   = 3'd2;
    localparam logic [2:0] KIND_NULL  = 3'd3;
    localparam logic [2:0] KIND_BEGIN = 3'd4;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_X     = 8'h78;

    // Character buffer: sign plus ten decimal digits
    localparam int BUF_DEPTH = 11;
    localparam int LOAD_W    = 8;

    localparam logic [30:0] TOTAL_MAX = 31'h7fff_ffff;

    // ceil(2^35 / 10): q = (m * DEC_RECIP) >> 35 is m / 10 for any 32-bit m
    localparam logic [31:0] DEC_RECIP = 32'hcccc_cccd;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // "(null)" stored last character first, buffer drains from the top
    localparam logic [7:0] NULL_REV [6] = '{8'h29, 8'h6c, 8'h6c, 8'h75, 8'h6e, 8'h28};

    typedef enum logic [1:0] {
        AW_NONE = 2'd0,
        AW_STR  = 2'd1,
        AW_DEC  = 2'd2,
        AW_HEX  = 2'd3
    } t_aw;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DEC  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic dec_step;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic will_emit;
        logic will_dec;
        logic dec_done;
        logic last_byte;
    } t_sts;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

endpackage

// ===== rtl/core/pf_if.sv =====
// Input item channel
interface pf_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         byte_in;
    logic signed [31:0] value;

    modport source (output valid, output kind, output byte_in, output value, input ready);
    modport sink   (input valid, input kind, input byte_in, input value, output ready);
endinterface

// Output byte channel
interface pf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic [30:0] total;

    modport source (output valid, output out_byte, output run_last, output total, input ready);
    modport sink   (input valid, input out_byte, input run_last, input total, output ready);
endinterface

// ===== rtl/core/pf_dp.sv =====
module pf_dp import pf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [2:0]         i_kind,
    input  logic [7:0]         i_byte_in,
    input  logic signed [31:0] i_value,
    output t_sts               o_sts,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic [30:0]        o_total
);

    // Control state
    logic        r_pend;
    t_aw         r_aw;
    logic [30:0] r_total;
    logic [3:0]  r_len;

    // Payload
    logic [7:0]  r_buf [BUF_DEPTH];
    logic [31:0] r_mag;
    logic        r_neg;

    logic        n_pend;
    t_aw         n_aw;
    logic [3:0]  ld_len;
    logic [7:0]  ld_buf [LOAD_W];
    logic        ld_dec;
    logic        ld_clr;
    logic [3:0]  hex_len;
    logic [31:0] v_bits;

    logic [63:0] prod;
    logic [31:0] quo;
    logic [31:0] q10;
    logic [31:0] diff;
    logic        dec_done;
    logic [3:0]  rd_idx;
    logic [30:0] inc_total;

    assign v_bits = i_value;

    // Decode one accepted item against the conversion state
    always_comb begin
        n_pend  = r_pend;
        n_aw    = r_aw;
        ld_len  = 4'd0;
        ld_dec  = 1'b0;
        ld_clr  = 1'b0;
        hex_len = 4'd1;
        for (int k = 0; k < LOAD_W; k++) begin
            ld_buf[k] = CH_NUL;
        end
        for (int k = 0; k < LOAD_W; k++) begin
            if (v_bits[4*k +: 4] != 4'h0) begin
                hex_len = 4'(k + 1);
            end
        end
        case (i_kind)
            KIND_FMT: begin
                n_aw = AW_NONE;
                if (r_pend) begin
                    n_pend = 1'b0;
                    if (i_byte_in == CH_S) begin
                        n_aw = AW_STR;
                    end else if (i_byte_in == CH_D) begin
                        n_aw = AW_DEC;
                    end else if (i_byte_in == CH_X) begin
                        n_aw = AW_HEX;
                    end else if (i_byte_in inside {CH_PCT, CH_NUL}) begin
                        ld_buf[0] = CH_PCT;
                        ld_len    = 4'd1;
                    end else begin
                        // stray percent goes out first, then the byte itself
                        ld_buf[1] = CH_PCT;
                        ld_buf[0] = i_byte_in;
                        ld_len    = 4'd2;
                    end
                end else if (i_byte_in == CH_PCT) begin
                    n_pend = 1'b1;
                end else if (i_byte_in != CH_NUL) begin
                    ld_buf[0] = i_byte_in;
                    ld_len    = 4'd1;
                end
            end
            KIND_INT: begin
                if (r_aw == AW_DEC) begin
                    ld_dec = 1'b1;
                    n_aw   = AW_NONE;
                end else if (r_aw == AW_HEX) begin
                    for (int k = 0; k < LOAD_W; k++) begin
                        ld_buf[k] = hex_char(v_bits[4*k +: 4]);
                    end
                    ld_len = hex_len;
                    n_aw   = AW_NONE;
                end
            end
            KIND_STR: begin
                if (r_aw == AW_STR) begin
                    if (i_byte_in == CH_NUL) begin
                        n_aw = AW_NONE;
                    end else begin
                        ld_buf[0] = i_byte_in;
                        ld_len    = 4'd1;
                    end
                end
            end
            KIND_NULL: begin
                if (r_aw == AW_STR) begin
                    for (int k = 0; k < 6; k++) begin
                        ld_buf[k] = NULL_REV[k];
                    end
                    ld_len = 4'd6;
                    n_aw   = AW_NONE;
                end
            end
            KIND_BEGIN: begin
                n_pend = 1'b0;
                n_aw   = AW_NONE;
                ld_clr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Divide by ten: reciprocal multiply, remainder from the low bits
    assign prod     = {32'd0, r_mag} * {32'd0, DEC_RECIP};
    assign quo      = {3'b000, prod[63:35]};
    assign q10      = {quo[28:0], 3'b000} + {quo[30:0], 1'b0};
    assign diff     = r_mag - q10;
    assign dec_done = (quo == 32'd0);

    // Output side reads the buffer top-down
    assign rd_idx     = 4'(r_len - 4'd1);
    assign inc_total  = (r_total == TOTAL_MAX) ? r_total : r_total + 31'd1;
    assign o_out_byte = r_buf[rd_idx];
    assign o_run_last = (r_len == 4'd1);
    assign o_total    = inc_total;

    assign o_sts.will_emit = (ld_len != 4'd0);
    assign o_sts.will_dec  = ld_dec;
    assign o_sts.dec_done  = dec_done;
    assign o_sts.last_byte = o_run_last;

    // Conversion state, byte count and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_aw    <= AW_NONE;
            r_total <= 31'd0;
            r_len   <= 4'd0;
        end else begin
            if (i_cmd.accept) begin
                r_pend <= n_pend;
                r_aw   <= n_aw;
                r_len  <= ld_dec ? 4'd0 : ld_len;
                if (ld_clr) begin
                    r_total <= 31'd0;
                end
            end
            if (i_cmd.dec_step) begin
                r_len <= r_len + 4'd1 + {3'b000, dec_done & r_neg};
            end
            if (i_cmd.pop) begin
                r_len   <= r_len - 4'd1;
                r_total <= inc_total;
            end
        end
    end

    // Character buffer and decimal magnitude
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int k = 0; k < LOAD_W; k++) begin
                r_buf[k] <= ld_buf[k];
            end
            r_neg <= v_bits[31];
            r_mag <= v_bits[31] ? (~v_bits + 32'd1) : v_bits;
        end
        if (i_cmd.dec_step) begin
            r_buf[r_len] <= CH_ZERO + {4'h0, diff[3:0]};
            if (dec_done && r_neg) begin
                r_buf[4'(r_len + 4'd1)] <= CH_MINUS;
            end
            r_mag <= quo;
        end
    end

endmodule

// ===== rtl/core/pf_ctrl.sv =====
`include "assert_macros.svh"

module pf_ctrl import pf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = (r_state == S_EMIT);
    assign o_cmd.accept   = i_in_valid & o_in_ready;
    assign o_cmd.dec_step = (r_state == S_DEC);
    assign o_cmd.pop      = o_out_valid & i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    if (i_sts.will_dec) begin
                        n_state = S_DEC;
                    end else if (i_sts.will_emit) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DEC: begin
                if (i_sts.dec_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.pop && i_sts.last_byte) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PF_ASSERT(a_no_overlap, !(o_in_ready && o_out_valid), "input and output both open")
    `PF_ASSERT(a_last_frees, (o_cmd.pop && i_sts.last_byte) |=> o_in_ready, "no return to idle")
    `PF_ASSERT(a_dec_to_emit, (o_cmd.dec_step && i_sts.dec_done) |=> o_out_valid, "digits lost")
    `PF_ASSERT(a_dec_needs_entry, $rose(o_cmd.dec_step) |-> $past(o_cmd.accept), "stray digit loop")

endmodule

// ===== rtl/core/printf_formatter_s_d_x_top.sv =====
// Streaming format engine for %s, %d, %x and %%.
// Input channel i_in carries one item per handshake: a format byte, an
// integer argument, a string byte, a null string or the start of a call.
// Output channel o_out carries one character per handshake, with a flag on the
// last character an input caused and the saturating count since call start.
// Both channels move an item at a rising edge where valid and ready are high.
// The block works on one input at a time: ready is high only when idle.
// An input with no output leaves ready high. Otherwise the first character is
// offered the cycle after acceptance, or for %d the cycle after the last digit
// step, and one follows per cycle while the receiver takes them; ready returns
// the cycle after the last one is taken. A %d argument first spends one cycle
// per decimal digit (1 to 10) in the divide-by-ten unit before its up to 11
// characters go out. A receiver stall simply holds the current character and
// the count. Synchronous reset clears the conversion state, the count and the
// buffer level.
module printf_formatter_s_d_x_top import pf_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    pf_in_if.sink   i_in,
    pf_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    pf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // Conversion datapath
    pf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_kind     (i_in.kind),
        .i_byte_in  (i_in.byte_in),
        .i_value    (i_in.value),
        .o_sts      (sts),
        .o_out_byte (o_out.out_byte),
        .o_run_last (o_out.run_last),
        .o_total    (o_out.total)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pf_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 420;
    localparam int          STALL_AT     = 200;
    localparam int          STALL_CYCLES = 300;
    localparam logic [2:0]  KIND_UNUSED  = 3'd7;
    localparam logic [7:0]  CH_LOWER_A   = 8'h61;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  chr;
        logic [31:0] value;
        logic        has_text;
    } fmt_item_t;

    typedef struct packed {
        logic [7:0]  chr;
        logic        last;
        logic [30:0] total;
    } char_rec_t;

    logic i_clk;
    logic i_rst_n;

    pf_in_if  in_ch ();
    pf_out_if out_ch ();

    printf_formatter_s_d_x_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Directed items; rows with has_text set take their output from directed_text
    localparam int N_DIRECTED = 32;
    fmt_item_t directed_rows [N_DIRECTED] = '{
        '{KIND_BEGIN, CH_NUL,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   8'h41,   32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_D,    32'h0000_0000, 1'b1},
        '{KIND_INT,   CH_NUL,  32'h8000_0000, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_X,    32'h0000_0000, 1'b1},
        '{KIND_INT,   CH_NUL,  32'hffff_ffff, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_D,    32'h0000_0000, 1'b1},
        '{KIND_INT,   CH_NUL,  32'h7fff_ffff, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_X,    32'h0000_0000, 1'b1},
        '{KIND_INT,   CH_NUL,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_S,    32'h0000_0000, 1'b1},
        '{KIND_STR,   8'hff,   32'h0000_0000, 1'b0},
        '{KIND_STR,   CH_NUL,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_S,    32'h0000_0000, 1'b1},
        '{KIND_NULL,  CH_NUL,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_D,    32'h0000_0000, 1'b1},
        '{KIND_STR,   8'h7a,   32'h0000_0000, 1'b1},
        '{KIND_FMT,   8'hff,   32'h0000_0000, 1'b0},
        '{KIND_UNUSED, 8'hff,  32'hffff_ffff, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   8'h71,   32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_PCT,  32'h0000_0000, 1'b1},
        '{KIND_FMT,   CH_NUL,  32'h0000_0000, 1'b1}
    };
    string directed_text [N_DIRECTED] = '{
        "", "A", "", "", "-2147483648", "", "", "ffffffff", "", "", "2147483647",
        "", "", "0", "", "", "", "", "", "", "(null)", "", "", "", "", "",
        "", "%", "", "%q", "", "%"
    };

    fmt_item_t  items_q [$];
    string      texts_q [$];
    char_rec_t  expected_chars [$];
    logic [7:0] char_q [$];

    fmt_item_t  cur_item;
    string      cur_text;

    // Formatter state mirror
    logic        pct_pending;
    t_aw         awaited;
    logic [30:0] chars_out;

    int  n_errors;
    int  n_cycles;
    bit  feed_done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run time guard
    initial n_cycles = 0;
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- Predictor ----------------

    function automatic void put_decimal(logic [31:0] bits);
        logic [31:0] mag;
        logic [7:0]  digs [$];
        mag = bits;
        if (bits[31]) begin
            char_q.push_back(CH_MINUS);
            mag = ~bits + 32'd1;
        end
        do begin
            digs.push_front(CH_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
        end while (mag != 32'd0);
        foreach (digs[i]) char_q.push_back(digs[i]);
    endfunction

    function automatic void put_hex(logic [31:0] bits);
        logic [31:0] rest;
        logic [7:0]  nib;
        logic [7:0]  digs [$];
        rest = bits;
        do begin
            nib = {4'd0, rest[3:0]};
            digs.push_front(nib < 8'd10 ? CH_ZERO + nib : CH_LOWER_A + nib - 8'd10);
            rest = rest >> 4;
        end while (rest != 32'd0);
        foreach (digs[i]) char_q.push_back(digs[i]);
    endfunction

    function automatic void on_format_byte(logic [7:0] b);
        awaited = AW_NONE;
        if (pct_pending) begin
            pct_pending = 1'b0;
            if (b == CH_S) begin
                awaited = AW_STR;
                return;
            end
            if (b == CH_D) begin
                awaited = AW_DEC;
                return;
            end
            if (b == CH_X) begin
                awaited = AW_HEX;
                return;
            end
            char_q.push_back(CH_PCT);
            if (b == CH_PCT) return;
        end
        if (b == CH_NUL) return;
        if (b == CH_PCT) begin
            pct_pending = 1'b1;
            return;
        end
        char_q.push_back(b);
    endfunction

    // Fills char_q with the characters one accepted item produces
    function automatic void format_step(fmt_item_t it);
        string nul_txt;
        nul_txt = "(null)";
        char_q.delete();
        case (it.kind)
            KIND_FMT: on_format_byte(it.chr);
            KIND_INT: begin
                if (awaited == AW_DEC) begin
                    put_decimal(it.value);
                    awaited = AW_NONE;
                end else if (awaited == AW_HEX) begin
                    put_hex(it.value);
                    awaited = AW_NONE;
                end
            end
            KIND_STR: begin
                if (awaited == AW_STR) begin
                    if (it.chr == CH_NUL) awaited = AW_NONE;
                    else char_q.push_back(it.chr);
                end
            end
            KIND_NULL: begin
                if (awaited == AW_STR) begin
                    foreach (nul_txt[i]) char_q.push_back(nul_txt[i]);
                    awaited = AW_NONE;
                end
            end
            KIND_BEGIN: begin
                pct_pending = 1'b0;
                awaited     = AW_NONE;
                chars_out   = '0;
            end
            default: ;
        endcase
    endfunction

    // Queue the characters with their running count
    function automatic void queue_chars();
        char_rec_t rec;
        foreach (char_q[i]) begin
            if (chars_out < TOTAL_MAX) chars_out = chars_out + 31'd1;
            rec.chr   = char_q[i];
            rec.last  = (i == char_q.size() - 1);
            rec.total = chars_out;
            expected_chars.push_back(rec);
        end
    endfunction

    // ---------------- Checker ----------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_chars.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected char expected none, got chr=%h last=%b total=%0d",
                             $time, out_ch.out_byte, out_ch.run_last, out_ch.total);
                end else begin
                    if (out_ch.out_byte !== expected_chars[0].chr) begin
                        n_errors++;
                        $display("%0t: out_byte expected %h, got %h",
                                 $time, expected_chars[0].chr, out_ch.out_byte);
                    end
                    if (out_ch.run_last !== expected_chars[0].last) begin
                        n_errors++;
                        $display("%0t: run_last expected %b, got %b",
                                 $time, expected_chars[0].last, out_ch.run_last);
                    end
                    if (out_ch.total !== expected_chars[0].total) begin
                        n_errors++;
                        $display("%0t: total expected %0d, got %0d",
                                 $time, expected_chars[0].total, out_ch.total);
                    end
                    void'(expected_chars.pop_front());
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                format_step(cur_item);
                if (cur_item.has_text) begin
                    char_q.delete();
                    foreach (cur_text[i]) char_q.push_back(cur_text[i]);
                end
                queue_chars();
            end
        end
    end

    // ---------------- Stimulus generation ----------------

    function automatic void add_item(logic [2:0] kind, logic [7:0] chr, logic [31:0] value);
        fmt_item_t it;
        it.kind     = kind;
        it.chr      = chr;
        it.value    = value;
        it.has_text = 1'b0;
        items_q.push_back(it);
        texts_q.push_back("");
    endfunction

    // Argument values biased toward digit-count edges and extremes
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 9));
            1: return 32'(-int'($urandom_range(1, 1000)));
            2: begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    3: return 32'd999_999_999;
                    4: return 32'd1_000_000_000;
                    default: return 32'h0;
                endcase
            end
            3: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic void gen_random();
        int         useful;
        int         pick;
        int         len;
        logic [7:0] b;
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                add_item(KIND_BEGIN, 8'($urandom), $urandom);
                useful++;
            end else if (pick < 30) begin
                // literal text
                b = 8'($urandom_range(1, 255));
                if (b == CH_PCT) b = 8'h2e;
                add_item(KIND_FMT, b, $urandom);
                useful++;
            end else if (pick < 34) begin
                add_item(KIND_FMT, CH_NUL, $urandom);
                useful++;
            end else if (pick < 48) begin
                add_item(KIND_FMT, CH_PCT, $urandom);
                add_item(KIND_FMT, CH_D, $urandom);
                add_item(KIND_INT, 8'($urandom), rand_word());
                useful += 3;
            end else if (pick < 60) begin
                add_item(KIND_FMT, CH_PCT, $urandom);
                add_item(KIND_FMT, CH_X, $urandom);
                add_item(KIND_INT, 8'($urandom), rand_word());
                useful += 3;
            end else if (pick < 72) begin
                // string, mostly terminated
                add_item(KIND_FMT, CH_PCT, $urandom);
                add_item(KIND_FMT, CH_S, $urandom);
                len = $urandom_range(0, 5);
                repeat (len) add_item(KIND_STR, 8'($urandom_range(1, 255)), $urandom);
                if ($urandom_range(0, 4) != 0) add_item(KIND_STR, CH_NUL, $urandom);
                useful += 3 + len;
            end else if (pick < 76) begin
                add_item(KIND_FMT, CH_PCT, $urandom);
                add_item(KIND_FMT, CH_S, $urandom);
                add_item(KIND_NULL, 8'($urandom), $urandom);
                useful += 3;
            end else if (pick < 81) begin
                add_item(KIND_FMT, CH_PCT, $urandom);
                add_item(KIND_FMT, CH_PCT, $urandom);
                useful += 2;
            end else if (pick < 86) begin
                add_item(KIND_FMT, CH_PCT, $urandom);
                add_item(KIND_FMT, 8'($urandom), $urandom);
                useful += 2;
            end else begin
                // noise: unused kinds, orphan or wrong-kind arguments, cancels
                case ($urandom_range(0, 3))
                    0: add_item(3'($urandom_range(5, 7)), 8'($urandom), $urandom);
                    1: add_item(3'($urandom_range(1, 3)), 8'($urandom), $urandom);
                    2: begin
                        add_item(KIND_FMT, CH_PCT, $urandom);
                        add_item(KIND_FMT, CH_D, $urandom);
                        add_item(KIND_STR, 8'($urandom), $urandom);
                        add_item(KIND_NULL, 8'($urandom), $urandom);
                        add_item(KIND_INT, 8'($urandom), rand_word());
                        useful += 3;
                    end
                    default: begin
                        add_item(KIND_FMT, CH_PCT, $urandom);
                        add_item(KIND_FMT, CH_X, $urandom);
                        add_item(KIND_FMT, 8'($urandom), $urandom);
                        useful += 3;
                    end
                endcase
            end
        end
    endfunction

    // ---------------- Output side ----------------

    initial begin
        int  gap;
        int  n_taken;
        bit  calm;
        bit  stalled;
        out_ch.ready = 1'b0;
        n_taken = 0;
        calm    = 1'b0;
        stalled = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 3);
            // one long hold-off so the block backs up into its input
            if (!stalled && n_taken == STALL_AT) begin
                gap     = STALL_CYCLES;
                stalled = 1'b1;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            n_taken++;
            @(negedge i_clk);
        end
    end

    // ---------------- Input side and run control ----------------

    initial begin
        int  gap;
        bit  calm;
        fmt_item_t it;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_FMT;
        in_ch.byte_in = CH_NUL;
        in_ch.value   = '0;
        cur_item      = '0;
        cur_text      = "";
        pct_pending   = 1'b0;
        awaited       = AW_NONE;
        chars_out     = '0;
        n_errors      = 0;
        feed_done     = 1'b0;
        calm          = 1'b0;

        for (int i = 0; i < N_DIRECTED; i++) begin
            items_q.push_back(directed_rows[i]);
            texts_q.push_back(directed_text[i]);
        end
        gen_random();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < items_q.size(); k++) begin
            if ($urandom_range(0, 31) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            it = items_q[k];
            in_ch.kind    <= it.kind;
            in_ch.byte_in <= it.chr;
            in_ch.value   <= it.value;
            cur_item      <= it;
            cur_text      <= texts_q[k];
            in_ch.valid   <= 1'b1;
            do @(posedge i_clk); while (!in_ch.ready);
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b0;
        feed_done = 1'b1;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
